// ===== hw/rtl/ssid_pkg.sv =====
`default_nettype none
package ssid_pkg;

  // Deepest body store the block ever builds; also the most results one answer holds.
  localparam int unsigned StoreMax = 32;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TARGET_ID = 2'd0;
  localparam logic [1:0] CFG_MAX_LEN   = 2'd1;
  localparam logic [1:0] CFG_HEX_UPPER = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_CHARS = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_NONE  = 2'd2;

  localparam logic [2:0] CNT_NONE   = 3'd0;
  localparam logic [2:0] CNT_PLAIN  = 3'd1;
  localparam logic [2:0] CNT_ESCAPE = 3'd4;

  localparam logic [6:0] CH_ZERO      = 7'h30;
  localparam logic [6:0] CH_UPPER_A   = 7'h41;
  localparam logic [6:0] CH_LOWER_A   = 7'h61;
  localparam logic [6:0] CH_BACKSLASH = 7'h5C;
  localparam logic [6:0] CH_X         = 7'h78;

  typedef enum logic [1:0] {
    PH_ID,
    PH_LEN,
    PH_BODY
  } ssid_phase_e;

  typedef enum logic [1:0] {
    S_PARSE,
    S_READ,
    S_LOAD
  } ssid_state_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       frame_end;
  } ssid_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] char_count;
    logic [6:0] out_char0;
    logic [6:0] out_char1;
    logic [6:0] out_char2;
    logic [6:0] out_char3;
    logic       last_result;
  } ssid_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic rd_issue;
    logic load_body;
  } ssid_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic emit_start;
    logic out_free;
    logic last_byte;
  } ssid_stat_t;

  function automatic logic [6:0] hex_char(logic [3:0] v, logic upper);
    logic [6:0] base;
    base = upper ? CH_UPPER_A : CH_LOWER_A;
    if (v < 4'd10) begin
      return CH_ZERO + {3'b000, v};
    end
    return base + {3'b000, v} - 7'd10;
  endfunction

  function automatic ssid_out_t fmt_byte(logic [7:0] b, logic upper, logic last);
    ssid_out_t r;
    r.status      = STAT_CHARS;
    r.last_result = last;
    if (b >= 8'h20 && b <= 8'h7E) begin
      r.char_count = CNT_PLAIN;
      r.out_char0  = b[6:0];
      r.out_char1  = '0;
      r.out_char2  = '0;
      r.out_char3  = '0;
    end else begin
      r.char_count = CNT_ESCAPE;
      r.out_char0  = CH_BACKSLASH;
      r.out_char1  = CH_X;
      r.out_char2  = hex_char(b[7:4], upper);
      r.out_char3  = hex_char(b[3:0], upper);
    end
    return r;
  endfunction

  function automatic ssid_out_t flag_result(logic [1:0] status);
    ssid_out_t r;
    r             = '0;
    r.status      = status;
    r.char_count  = CNT_NONE;
    r.last_result = 1'b1;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ssid_ctrl.sv =====
`default_nettype none
module ssid_ctrl
  import ssid_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  input  ssid_stat_t stat_i,
  output logic       in_ready_o,
  output ssid_cmd_t  cmd_o
);

  ssid_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_PARSE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    case (state_q)
      S_PARSE: begin
        // A word may come in while the previous result is being taken.
        in_ready_o   = stat_i.out_free;
        cmd_o.accept = in_valid_i && stat_i.out_free;
        if (cmd_o.accept && stat_i.emit_start) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_LOAD;
      end
      S_LOAD: begin
        if (stat_i.out_free) begin
          cmd_o.load_body = 1'b1;
          state_d         = stat_i.last_byte ? S_PARSE : S_READ;
        end
      end
      default: begin
        state_d = S_PARSE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ssid_dpath.sv =====
`default_nettype none
module ssid_dpath
  import ssid_pkg::*;
#(
  parameter int unsigned MAX_BODY_BYTES = 32
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  ssid_in_t   in_data_i,
  input  wire        cfg_valid_i,
  input  wire [1:0]  cfg_index_i,
  input  wire [7:0]  cfg_data_i,
  input  wire        out_ready_i,
  input  ssid_cmd_t  cmd_i,
  output ssid_stat_t stat_o,
  output logic       out_valid_o,
  output ssid_out_t  out_data_o
);

  localparam int unsigned Depth = (MAX_BODY_BYTES < StoreMax) ? MAX_BODY_BYTES : StoreMax;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW    = $clog2(Depth + 1);

  // Configuration registers.
  logic [7:0] target_q;
  logic [5:0] max_len_q;
  logic       upper_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q  <= 8'd0;
      max_len_q <= 6'd32;
      upper_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TARGET_ID: target_q  <= cfg_data_i;
        CFG_MAX_LEN:   max_len_q <= cfg_data_i[5:0];
        CFG_HEX_UPPER: upper_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Parser state.
  ssid_phase_e   phase_q, phase_d;
  logic [7:0]    id_q, id_d;
  logic [7:0]    remain_q, remain_d;
  logic [CW-1:0] blen_q, blen_d;
  logic          match_q, match_d;
  logic          sent_q, sent_d;
  logic [CW-1:0] emit_len_q, emit_len_d;
  logic [AW-1:0] rd_idx_q;

  logic          out_valid_q;
  ssid_out_t     out_q;

  logic [7:0]    mem [Depth];
  logic [7:0]    rdata_q;

  logic [5:0]    limit;
  logic          wr_en;
  logic          complete;
  logic          res_load;
  ssid_out_t     res_d;
  logic          emit_start;
  logic          out_free;
  logic          out_load;
  ssid_out_t     out_d;
  logic [7:0]    b;
  logic          fend;

  assign b    = in_data_i.in_byte;
  assign fend = in_data_i.frame_end;
  assign limit = (max_len_q > 6'(Depth)) ? 6'(Depth) : max_len_q;

  always_comb begin
    phase_d    = phase_q;
    id_d       = id_q;
    remain_d   = remain_q;
    blen_d     = blen_q;
    match_d    = match_q;
    sent_d     = sent_q;
    emit_len_d = emit_len_q;
    wr_en      = 1'b0;
    complete   = 1'b0;
    res_load   = 1'b0;
    res_d      = flag_result(STAT_NONE);
    emit_start = 1'b0;
    if (sent_q) begin
      // The answer is out; skip the rest of the frame.
      if (fend) begin
        sent_d = 1'b0;
      end
    end else begin
      case (phase_q)
        PH_ID: begin
          id_d    = b;
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          remain_d = b;
          blen_d   = '0;
          match_d  = (id_q == target_q) && (b <= {2'b00, limit});
          if (b == 8'd0) begin
            complete = 1'b1;
          end else begin
            phase_d = PH_BODY;
          end
        end
        PH_BODY: begin
          if (match_q && blen_q < CW'(Depth)) begin
            wr_en  = 1'b1;
            blen_d = blen_q + CW'(1);
          end
          if (remain_q != 8'd0) begin
            remain_d = remain_q - 8'd1;
          end
          if (remain_d == 8'd0) begin
            complete = 1'b1;
          end
        end
        default: begin
          phase_d = PH_ID;
        end
      endcase

      if (complete && match_d) begin
        phase_d = PH_ID;
        if (blen_d == '0) begin
          res_load = 1'b1;
          res_d    = flag_result(STAT_EMPTY);
        end else begin
          emit_start = 1'b1;
          emit_len_d = blen_d;
        end
        match_d = 1'b0;
        sent_d  = !fend;
        if (fend) begin
          remain_d = '0;
          blen_d   = '0;
        end
      end else if (fend) begin
        res_load = 1'b1;
        res_d    = flag_result(STAT_NONE);
        phase_d  = PH_ID;
        remain_d = '0;
        blen_d   = '0;
        match_d  = 1'b0;
        sent_d   = 1'b0;
      end else if (complete) begin
        phase_d = PH_ID;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_ID;
      id_q       <= '0;
      remain_q   <= '0;
      blen_q     <= '0;
      match_q    <= 1'b0;
      sent_q     <= 1'b0;
      emit_len_q <= '0;
      rd_idx_q   <= '0;
    end else begin
      if (cmd_i.accept) begin
        phase_q    <= phase_d;
        id_q       <= id_d;
        remain_q   <= remain_d;
        blen_q     <= blen_d;
        match_q    <= match_d;
        sent_q     <= sent_d;
        emit_len_q <= emit_len_d;
        if (emit_start) begin
          rd_idx_q <= '0;
        end
      end else if (cmd_i.load_body) begin
        rd_idx_q <= rd_idx_q + AW'(1);
      end
    end
  end

  // Body store: one write port while parsing, one registered read port while emitting.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && wr_en) begin
      mem[blen_q[AW-1:0]] <= b;
    end
    if (cmd_i.rd_issue) begin
      rdata_q <= mem[rd_idx_q];
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_load = 1'b0;
    out_d    = out_q;
    if (cmd_i.load_body) begin
      out_load = 1'b1;
      out_d    = fmt_byte(rdata_q, upper_q, stat_o.last_byte);
    end else if (cmd_i.accept && res_load) begin
      out_load = 1'b1;
      out_d    = res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign stat_o.emit_start = emit_start;
  assign stat_o.out_free   = out_free;
  assign stat_o.last_byte  = (CW'(rd_idx_q) + CW'(1)) == emit_len_q;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== hw/rtl/ssid_element_extractor.sv =====
// Extracts one information element body from a byte stream of id-length-value
// elements and sends it out as text, one result word per body byte.
// Input channel: one byte per word with a frame-end flag on the last byte.
// Output channel: one result word with status, character count, up to four
// characters and a last flag. Configuration channel: always ready, writes the
// target id, the body length limit and the hex letter case.
// A byte that completes no element or produces a not-found or empty result is
// taken without leaving S_PARSE; its result, if any, is valid the next cycle. After the
// byte that completes a matching non-empty element, the input is stalled and
// the body is sent one word at a time, each with one store read (S_READ) and
// one output load (S_LOAD); the input stays held until the last word is loaded,
// and each load also waits out any output stall.
// A stalled receiver holds the output register; the input is then ready only
// while that register is empty or being drained in the same cycle.
// Reset restores the configuration defaults (id 0, limit 32, lower case) and
// puts the parser at the start of a frame. The body store is not cleared;
// only entries written for the current element are ever read.
`default_nettype none
module ssid_element_extractor
  import ssid_pkg::*;
#(
  parameter int unsigned MAX_BODY_BYTES = 32
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  output logic      in_ready_o,
  input  ssid_in_t  in_data_i,
  output logic      out_valid_o,
  input  wire       out_ready_i,
  output ssid_out_t out_data_o,
  input  wire       cfg_valid_i,
  output logic      cfg_ready_o,
  input  wire [1:0] cfg_index_i,
  input  wire [7:0] cfg_data_i
);

  ssid_cmd_t  cmd;
  ssid_stat_t stat;

  assign cfg_ready_o = 1'b1;

  ssid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  ssid_dpath #(
    .MAX_BODY_BYTES (MAX_BODY_BYTES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // The body burst must hold off new input words.
  a_emit_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept && stat.emit_start |=> !in_ready_o)
    else $error("input accepted right after an emission started");

  a_flag_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != STAT_CHARS |->
      out_data_o.last_result && out_data_o.char_count == CNT_NONE)
    else $error("empty or not-found result is not a lone final word");

  a_char_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STAT_CHARS |->
      out_data_o.char_count == CNT_PLAIN || out_data_o.char_count == CNT_ESCAPE)
    else $error("character result with a bad count");

  a_no_double_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_body |-> !cmd.accept && !cmd.rd_issue)
    else $error("body load overlaps another datapath command");

endmodule
`default_nettype wire
